FILE: rtl/fea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_pkg: shared types and constants for the frame extract and restuff block
// Holds the request structs, the parser phase enum, status codes and the
// byte values used by the framer.
// ----------------------------------------------------------------------------
package fea_pkg;

  // Framing byte values.
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] END_BYTE  = 8'h7F;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // Most result items one input request can cause.
  localparam int CMD_SLOTS = 3;

  // Depth of the queue between the parser and the output sequencer.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SKIP,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CRC,
    PH_END,
    PH_ERROR
  } phase_t;

  // Per-item frame status.
  typedef enum logic [1:0] {
    FS_CONT,
    FS_COMMIT,
    FS_ABORT
  } fstat_t;

  // Per-buffer status.
  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNC,
    ST_END,
    ST_LONG
  } bstat_t;

  // Input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in_buffer;
  } in_req_t;

  // Result request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] frame_status;
    logic       buffer_done;
    logic [1:0] buffer_status;
    logic       last;
  } out_req_t;

  // One result item as planned by the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    fstat_t     fstat;
  } item_t;

  // Everything one input request causes, queued for the output sequencer.
  typedef struct packed {
    item_t [CMD_SLOTS-1:0] items;
    logic [1:0]            cnt;
    logic                  done;
    bstat_t                bstat;
  } cmd_t;

  // Append one item to a command.
  function automatic cmd_t add_item(cmd_t c, logic [7:0] d, logic v, fstat_t f);
    item_t it;
    it.data  = d;
    it.valid = v;
    it.fstat = f;
    case (c.cnt)
      2'd0: c.items[0] = it;
      2'd1: c.items[1] = it;
      2'd2: c.items[2] = it;
      default: c.items[0] = it;
    endcase
    c.cnt = c.cnt + 2'd1;
    return c;
  endfunction

endpackage

FILE: rtl/fea_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_front: frame parser
// Accepts input bytes, tracks the frame layout and the buffer status, and
// turns each byte that causes result items into one command listing them.
// ----------------------------------------------------------------------------
module fea_front #(
  parameter int MAX_BUFFER_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  fea_pkg::in_req_t in_data,
  input  logic            q_full,
  output logic            q_push,
  output fea_pkg::cmd_t   q_cmd
);

  localparam int CNT_W = $clog2(MAX_BUFFER_BYTES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BUFFER_BYTES);

  logic             bypass_r;
  fea_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]      bl_r, bl_nxt;
  logic [15:0]      pl_r, pl_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             open_r, open_nxt;
  fea_pkg::bstat_t  err_r, err_nxt;
  logic             acc;
  logic [15:0]      len;
  fea_pkg::cmd_t    cmd;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign len      = {bl_r[15:8], in_data.in_byte};
  assign q_push   = acc && (cmd.cnt != 2'd0);
  assign q_cmd    = cmd;

  // Bypass register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
    end else if (cfg_wr_en) begin
      bypass_r <= cfg_wr_data;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fea_pkg::PH_HUNT;
      bl_r    <= '0;
      pl_r    <= '0;
      cnt_r   <= '0;
      open_r  <= 1'b0;
      err_r   <= fea_pkg::ST_OK;
    end else if (acc) begin
      phase_r <= phase_nxt;
      bl_r    <= bl_nxt;
      pl_r    <= pl_nxt;
      cnt_r   <= cnt_nxt;
      open_r  <= open_nxt;
      err_r   <= err_nxt;
    end
  end

  // Next parser state and the command for this byte.
  always_comb begin
    phase_nxt = phase_r;
    bl_nxt    = bl_r;
    pl_nxt    = pl_r;
    cnt_nxt   = cnt_r;
    open_nxt  = open_r;
    err_nxt   = err_r;
    cmd       = '0;

    if (bypass_r) begin
      // Drop the byte; abort an open frame and clear the buffer state.
      if (open_r) begin
        cmd = fea_pkg::add_item(cmd, 8'h00, 1'b0, fea_pkg::FS_ABORT);
      end
      phase_nxt = fea_pkg::PH_HUNT;
      bl_nxt    = '0;
      pl_nxt    = '0;
      cnt_nxt   = '0;
      open_nxt  = 1'b0;
      err_nxt   = fea_pkg::ST_OK;
    end else if (phase_r != fea_pkg::PH_ERROR) begin
      // Saturating byte count for the buffer.
      if (cnt_r <= MAX_CNT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (cnt_nxt > MAX_CNT) begin
        err_nxt   = fea_pkg::ST_LONG;
        phase_nxt = fea_pkg::PH_ERROR;
        if (open_nxt) begin
          cmd = fea_pkg::add_item(cmd, 8'h00, 1'b0, fea_pkg::FS_ABORT);
        end
        open_nxt = 1'b0;
      end else begin
        case (phase_r)
          fea_pkg::PH_HUNT: begin
            if (in_data.in_byte == fea_pkg::FLAG_BYTE) begin
              phase_nxt = fea_pkg::PH_SKIP;
            end
          end
          fea_pkg::PH_SKIP: begin
            phase_nxt = fea_pkg::PH_LEN_HI;
          end
          fea_pkg::PH_LEN_HI: begin
            bl_nxt    = {in_data.in_byte, 8'h00};
            phase_nxt = fea_pkg::PH_LEN_LO;
          end
          fea_pkg::PH_LEN_LO: begin
            bl_nxt = len;
            if (len < 16'd2) begin
              err_nxt   = fea_pkg::ST_TRUNC;
              phase_nxt = fea_pkg::PH_ERROR;
              if (open_nxt) begin
                cmd = fea_pkg::add_item(cmd, 8'h00, 1'b0, fea_pkg::FS_ABORT);
              end
              open_nxt = 1'b0;
            end else begin
              pl_nxt = len - 16'd2;
              if (pl_nxt != 16'd0) begin
                cmd       = fea_pkg::add_item(cmd, fea_pkg::FLAG_BYTE, 1'b1,
                                              fea_pkg::FS_CONT);
                open_nxt  = 1'b1;
                phase_nxt = fea_pkg::PH_PAYLOAD;
              end else begin
                phase_nxt = fea_pkg::PH_CRC;
              end
            end
          end
          fea_pkg::PH_PAYLOAD: begin
            // Byte stuffing of flag and escape values.
            if (in_data.in_byte == fea_pkg::FLAG_BYTE) begin
              cmd = fea_pkg::add_item(cmd, fea_pkg::ESC_BYTE, 1'b1, fea_pkg::FS_CONT);
              cmd = fea_pkg::add_item(cmd, fea_pkg::ESC_FLAG, 1'b1, fea_pkg::FS_CONT);
            end else if (in_data.in_byte == fea_pkg::ESC_BYTE) begin
              cmd = fea_pkg::add_item(cmd, fea_pkg::ESC_BYTE, 1'b1, fea_pkg::FS_CONT);
              cmd = fea_pkg::add_item(cmd, fea_pkg::ESC_ESC, 1'b1, fea_pkg::FS_CONT);
            end else begin
              cmd = fea_pkg::add_item(cmd, in_data.in_byte, 1'b1, fea_pkg::FS_CONT);
            end
            pl_nxt = pl_r - 16'd1;
            bl_nxt = bl_r - 16'd1;
            if (pl_nxt == 16'd0) begin
              phase_nxt = fea_pkg::PH_CRC;
            end
          end
          fea_pkg::PH_CRC: begin
            bl_nxt = bl_r - 16'd1;
            if (bl_nxt == 16'd0) begin
              phase_nxt = fea_pkg::PH_END;
            end
          end
          fea_pkg::PH_END: begin
            if (in_data.in_byte == fea_pkg::END_BYTE) begin
              if (open_r) begin
                cmd = fea_pkg::add_item(cmd, fea_pkg::FLAG_BYTE, 1'b1,
                                        fea_pkg::FS_COMMIT);
              end
              open_nxt  = 1'b0;
              phase_nxt = fea_pkg::PH_HUNT;
            end else begin
              err_nxt   = fea_pkg::ST_END;
              phase_nxt = fea_pkg::PH_ERROR;
              if (open_nxt) begin
                cmd = fea_pkg::add_item(cmd, 8'h00, 1'b0, fea_pkg::FS_ABORT);
              end
              open_nxt = 1'b0;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end

      // The buffer ends inside a frame.
      if (in_data.last_in_buffer && phase_nxt != fea_pkg::PH_HUNT &&
          phase_nxt != fea_pkg::PH_ERROR) begin
        err_nxt   = fea_pkg::ST_TRUNC;
        phase_nxt = fea_pkg::PH_ERROR;
        if (open_nxt) begin
          cmd = fea_pkg::add_item(cmd, 8'h00, 1'b0, fea_pkg::FS_ABORT);
        end
        open_nxt = 1'b0;
      end
    end

    // Report on the final byte of the buffer and clear the buffer state.
    if (in_data.last_in_buffer) begin
      if (cmd.cnt == 2'd0) begin
        cmd = fea_pkg::add_item(cmd, 8'h00, 1'b0, fea_pkg::FS_CONT);
      end
      cmd.done  = 1'b1;
      cmd.bstat = bypass_r ? fea_pkg::ST_OK : err_nxt;
      phase_nxt = fea_pkg::PH_HUNT;
      bl_nxt    = '0;
      pl_nxt    = '0;
      cnt_nxt   = '0;
      open_nxt  = 1'b0;
      err_nxt   = fea_pkg::ST_OK;
    end
  end

  // An error phase always carries a latched error code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fea_pkg::PH_ERROR) |-> (err_r != fea_pkg::ST_OK))
    else $error("error phase without an error code");

  // An opening flag is outstanding only while a frame body is parsed.
  a_open_phase: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (phase_r == fea_pkg::PH_PAYLOAD || phase_r == fea_pkg::PH_CRC ||
                phase_r == fea_pkg::PH_END))
    else $error("opening flag outstanding outside a frame body");

endmodule

FILE: rtl/fea_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_queue: command queue
// Short first-in first-out queue that decouples the parser from the output
// sequencer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fea_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fea_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output fea_pkg::cmd_t head
);

  fea_pkg::cmd_t                 mem_r [fea_pkg::QDEPTH];
  logic [fea_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [fea_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [fea_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (cnt_r == fea_pkg::QCNT_W'(fea_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  // The parser never offers a command while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into a full queue");

endmodule

FILE: rtl/fea_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_back: output sequencer
// Walks the head command's items, one a cycle while the receiver does not
// stall, into the registered result port and tags each request's last item.
// ----------------------------------------------------------------------------
module fea_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  fea_pkg::cmd_t     q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fea_pkg::out_req_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  fea_pkg::out_req_t out_data_r, out_data_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              adv;
  logic              is_last;
  fea_pkg::item_t    cur;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign adv       = !out_valid_r || !out_stall;
  assign is_last   = (idx_r == q_head.cnt - 2'd1);

  // Pick the current item of the head command.
  always_comb begin
    case (idx_r)
      2'd0: cur = q_head.items[0];
      2'd1: cur = q_head.items[1];
      2'd2: cur = q_head.items[2];
      default: cur = q_head.items[0];
    endcase
  end

  // Load the output register and step through the command.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    q_pop         = 1'b0;
    if (adv) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_data_nxt.out_byte      = cur.data;
        out_data_nxt.byte_valid    = cur.valid;
        out_data_nxt.frame_status  = cur.fstat;
        out_data_nxt.buffer_done   = is_last && q_head.done;
        out_data_nxt.buffer_status = (is_last && q_head.done) ? q_head.bstat
                                                              : fea_pkg::ST_OK;
        out_data_nxt.last          = is_last;
        if (is_last) begin
          idx_nxt = 2'd0;
          q_pop   = 1'b1;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // A buffer report always closes the items of its request.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.buffer_done) |-> out_data_r.last)
    else $error("buffer report on an item that is not the last");

  // Queued commands are never empty.
  a_cmd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (q_head.cnt != 2'd0))
    else $error("empty command in the queue");

  // The item index stays inside the head command.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < q_head.cnt))
    else $error("item index beyond the head command");

endmodule

FILE: rtl/frame_extract_and_restuff.sv
`timescale 1ns / 1ps
// Path: an accepted input byte is written into the command queue, and its first result
// item then moves to the registered result port; further items follow one a cycle
// while the receiver does not stall. Throughput: one input byte per cycle while each
// byte makes one result item and the receiver does not stall; the single-byte output
// port sets the rate, as a stuffed payload byte makes two items and an abort adds one.
// Reset: synchronous active-low rst_n clears the parser, the queue, the output
// port and the bypass register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// frame_extract_and_restuff: streaming frame parser and byte-stuffing framer
// Parser front end, command queue and output sequencer, with a one-bit
// bypass configuration register.
// ----------------------------------------------------------------------------
module frame_extract_and_restuff #(
  parameter int MAX_BUFFER_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  fea_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fea_pkg::out_req_t out_data
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  fea_pkg::cmd_t q_cmd;
  fea_pkg::cmd_t q_head;

  // Parser.
  fea_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  // Command queue.
  fea_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  // Output sequencer.
  fea_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the frame extract and restuff block
// Feeds byte buffers made of noise, good frames, short lengths, bad end
// bytes, cut-off buffers and over-long buffers, with and without bypass.
// A behavioral parser in the bench predicts each stuffed output request, and
// a monitor compares every result field with the oldest prediction. Both
// sides of the block idle at random, and the receiver once holds off for a
// long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb;

  // A small buffer limit lets random buffers run past it now and then.
  localparam int MAX_BYTES   = 64;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_wr_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  fea_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fea_pkg::out_req_t out_data;

  frame_extract_and_restuff #(
    .MAX_BUFFER_BYTES(MAX_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be offered, and stuffed bytes still due at the output.
  fea_pkg::in_req_t  pending[$];
  fea_pkg::out_req_t due_results[$];
  logic [7:0]        buf_q[$];

  // Bench copy of the parser state and the bypass register.
  logic              bypass_q;
  fea_pkg::phase_t   ph;
  logic [15:0]       bytes_left;
  logic [15:0]       payload_left;
  logic [16:0]       seen;
  logic              opened;
  fea_pkg::bstat_t   err;
  fea_pkg::out_req_t step_items[fea_pkg::CMD_SLOTS];
  int                step_n;

  // Run bookkeeping.
  int  errors = 0;
  int  cycles = 0;
  int  n_in = 0;
  int  n_bypass_in = 0;
  int  n_out = 0;
  int  n_buffers = 0;
  int  n_commits = 0;
  int  n_aborts = 0;
  int  n_long = 0;
  int  items_made = 0;
  bit  calm = 1'b0;
  bit  in_took = 1'b0;

  // Return the parser to its state at the start of a buffer.
  task automatic clear_buffer();
    ph           = fea_pkg::PH_HUNT;
    bytes_left   = '0;
    payload_left = '0;
    seen         = '0;
    opened       = 1'b0;
    err          = fea_pkg::ST_OK;
  endtask

  // Append one result to those caused by the current request.
  task automatic put(logic [7:0] d, logic v, fea_pkg::fstat_t f);
    fea_pkg::out_req_t r;
    r              = '0;
    r.out_byte     = d;
    r.byte_valid   = v;
    r.frame_status = f;
    step_items[step_n] = r;
    step_n++;
  endtask

  // Latch an error; an open frame gets an abort mark.
  task automatic latch_error(fea_pkg::bstat_t code);
    err = code;
    ph  = fea_pkg::PH_ERROR;
    if (opened) begin
      put(8'h00, 1'b0, fea_pkg::FS_ABORT);
      opened = 1'b0;
    end
  endtask

  // Work out the stuffed output that one accepted byte causes.
  task automatic restuff_byte(fea_pkg::in_req_t r);
    logic [7:0] b;
    int i;
    b = r.in_byte;
    step_n = 0;
    if (bypass_q) begin
      if (opened) put(8'h00, 1'b0, fea_pkg::FS_ABORT);
      clear_buffer();
    end else if (ph != fea_pkg::PH_ERROR) begin
      if (seen <= MAX_BYTES) seen++;
      if (seen > MAX_BYTES) begin
        latch_error(fea_pkg::ST_LONG);
      end else begin
        case (ph)
          fea_pkg::PH_HUNT: begin
            if (b == fea_pkg::FLAG_BYTE) ph = fea_pkg::PH_SKIP;
          end
          fea_pkg::PH_SKIP: begin
            ph = fea_pkg::PH_LEN_HI;
          end
          fea_pkg::PH_LEN_HI: begin
            bytes_left = {b, 8'h00};
            ph = fea_pkg::PH_LEN_LO;
          end
          fea_pkg::PH_LEN_LO: begin
            bytes_left[7:0] = b;
            if (bytes_left < 16'd2) begin
              latch_error(fea_pkg::ST_TRUNC);
            end else begin
              payload_left = bytes_left - 16'd2;
              if (payload_left != 16'd0) begin
                put(fea_pkg::FLAG_BYTE, 1'b1, fea_pkg::FS_CONT);
                opened = 1'b1;
                ph = fea_pkg::PH_PAYLOAD;
              end else begin
                ph = fea_pkg::PH_CRC;
              end
            end
          end
          fea_pkg::PH_PAYLOAD: begin
            if (b == fea_pkg::FLAG_BYTE) begin
              put(fea_pkg::ESC_BYTE, 1'b1, fea_pkg::FS_CONT);
              put(fea_pkg::ESC_FLAG, 1'b1, fea_pkg::FS_CONT);
            end else if (b == fea_pkg::ESC_BYTE) begin
              put(fea_pkg::ESC_BYTE, 1'b1, fea_pkg::FS_CONT);
              put(fea_pkg::ESC_ESC, 1'b1, fea_pkg::FS_CONT);
            end else begin
              put(b, 1'b1, fea_pkg::FS_CONT);
            end
            payload_left--;
            bytes_left--;
            if (payload_left == 16'd0) ph = fea_pkg::PH_CRC;
          end
          fea_pkg::PH_CRC: begin
            bytes_left--;
            if (bytes_left == 16'd0) ph = fea_pkg::PH_END;
          end
          default: begin
            if (b == fea_pkg::END_BYTE) begin
              if (opened) put(fea_pkg::FLAG_BYTE, 1'b1, fea_pkg::FS_COMMIT);
              opened = 1'b0;
              ph = fea_pkg::PH_HUNT;
            end else begin
              latch_error(fea_pkg::ST_END);
            end
          end
        endcase
      end
      if (r.last_in_buffer && ph != fea_pkg::PH_HUNT && ph != fea_pkg::PH_ERROR)
        latch_error(fea_pkg::ST_TRUNC);
    end

    // The final byte of a buffer always reports the buffer status.
    if (r.last_in_buffer) begin
      if (step_n == 0) put(8'h00, 1'b0, fea_pkg::FS_CONT);
      step_items[step_n-1].buffer_done   = 1'b1;
      step_items[step_n-1].buffer_status = bypass_q ? fea_pkg::ST_OK : err;
      if (!bypass_q && err == fea_pkg::ST_LONG) n_long++;
      clear_buffer();
    end
    if (step_n > 0) step_items[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++) due_results.push_back(step_items[i]);
  endtask

  // One line per mismatch; printing stops after a while but counting does not.
  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 40)
      $display("mismatch at output %0d: %s is %0h, expected %0h", n_out, what, got, want);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add(logic [7:0] b);
    buf_q.push_back(b);
  endtask

  // Move the buffer under construction to the pending requests.
  task automatic ship(bit mark_last);
    fea_pkg::in_req_t r;
    int i;
    for (i = 0; i < buf_q.size(); i++) begin
      r.in_byte        = buf_q[i];
      r.last_in_buffer = mark_last && (i == buf_q.size() - 1);
      pending.push_back(r);
    end
    items_made += buf_q.size();
    buf_q.delete();
  endtask

  // Payload bytes lean toward the bytes that need escaping and the extremes.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(9))
      0: return fea_pkg::FLAG_BYTE;
      1: return fea_pkg::ESC_BYTE;
      2: return fea_pkg::END_BYTE;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Bytes between frames; a flag byte slips through only rarely.
  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == fea_pkg::FLAG_BYTE && $urandom_range(9) != 0) b = 8'h00;
    return b;
  endfunction

  // One frame with the given length field, closed by a good or a wrong end byte.
  task automatic add_frame(int field, bit bad_end);
    logic [7:0] b;
    int i;
    add(fea_pkg::FLAG_BYTE);
    add(8'($urandom_range(255)));
    add(field[15:8]);
    add(field[7:0]);
    for (i = 0; i < field - 2; i++) add(pick_payload());
    add(8'($urandom_range(255)));
    add(8'($urandom_range(255)));
    b = 8'($urandom_range(255));
    if (b == fea_pkg::END_BYTE) b = 8'h00;
    add(bad_end ? b : fea_pkg::END_BYTE);
  endtask

  // A buffer of noise and frames, sometimes cut short or run past the limit.
  task automatic random_buffer();
    int n_noise;
    int n_frames;
    int kind;
    int field;
    int cut;
    int i;
    n_noise = ($urandom_range(99) < 6) ? $urandom_range(40, 70) : $urandom_range(0, 3);
    for (i = 0; i < n_noise; i++) add(pick_noise());
    n_frames = $urandom_range(1, 3);
    for (i = 0; i < n_frames; i++) begin
      kind = $urandom_range(99);
      if (kind < 8) field = $urandom_range(0, 1);
      else if (kind >= 95) field = $urandom_range(13, 40);
      else field = $urandom_range(2, 12);
      add_frame(field, kind >= 8 && kind < 16);
    end
    n_noise = $urandom_range(0, 2);
    for (i = 0; i < n_noise; i++) add(pick_noise());
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(1, buf_q.size());
      while (buf_q.size() > cut) void'(buf_q.pop_back());
    end
    ship(1'b1);
  endtask

  task automatic random_buffers(int count);
    int start;
    start = items_made;
    while (items_made - start < count) random_buffer();
  endtask

  // Wait until every request is taken and every result is in, then let the
  // block settle in case the last bytes caused nothing.
  task automatic wait_idle();
    while (pending.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_bypass(logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    bypass_q = v;
  endtask

  // Reset, then the test phases.
  initial begin
    bypass_q = 1'b0;
    clear_buffer();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_bypass(1'b0);

    // Escaped flag and escape bytes in a committed frame.
    add(fea_pkg::FLAG_BYTE); add(8'h00); add(8'h00); add(8'h04);
    add(fea_pkg::FLAG_BYTE); add(fea_pkg::ESC_BYTE); add(8'hC1); add(8'hC2);
    add(fea_pkg::END_BYTE);
    ship(1'b1);
    // Zero-length payload: nothing is sent but the end byte is checked.
    add(fea_pkg::FLAG_BYTE); add(8'hFF); add(8'h00); add(8'h02);
    add(8'hC1); add(8'hC2); add(fea_pkg::END_BYTE);
    ship(1'b1);
    // Length field below two, then a byte ignored behind the error.
    add(fea_pkg::FLAG_BYTE); add(8'h00); add(8'h00); add(8'h00); add(8'h55);
    ship(1'b1);
    // Wrong end byte aborts the open frame.
    add(fea_pkg::FLAG_BYTE); add(8'h00); add(8'h00); add(8'h03);
    add(8'hFF); add(8'hC1); add(8'hC2); add(8'h80);
    ship(1'b1);
    // Largest length field, buffer ends inside the payload.
    add(fea_pkg::FLAG_BYTE); add(8'h00); add(8'hFF); add(8'hFF); add(8'hFF);
    ship(1'b1);
    wait_idle();

    // Random buffers, leaving a frame open at the end of the phase.
    random_buffers(130);
    add(fea_pkg::FLAG_BYTE); add(8'h00); add(8'h00); add(8'h08); add(8'h11);
    add(8'h22);
    ship(1'b0);
    wait_idle();

    // Bypass: the open frame is aborted and everything else is dropped.
    write_bypass(1'b1);
    random_buffers(30);
    wait_idle();

    // Back to parsing, first with no idling on either side.
    write_bypass(1'b0);
    calm = 1'b1;
    random_buffers(150);
    wait_idle();
    calm = 1'b0;
    random_buffers(50);
    wait_idle();

    $display("Sent %0d bytes (%0d under bypass) in %0d buffers, %0d over the size limit.",
             n_in, n_bypass_in, n_buffers, n_long);
    $display("Checked %0d output bytes: %0d frames committed, %0d aborted.",
             n_out, n_commits, n_aborts);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // Take the offered request at the rising edge and predict its results.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      restuff_byte(in_data);
      void'(pending.pop_front());
      n_in++;
      if (bypass_q) n_bypass_in++;
      if (in_data.last_in_buffer) n_buffers++;
      in_took <= 1'b1;
    end else begin
      in_took <= 1'b0;
    end
  end

  // Offer the next request at the falling edge; a stalled request holds.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= pending[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // Receiver stall, with one long hold-off once traffic is flowing.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_out >= 120) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    fea_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing due, out_byte", out_data.out_byte, 0);
      end else begin
        want = due_results.pop_front();
        if (out_data.out_byte != want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.byte_valid != want.byte_valid)
          report_mismatch("byte_valid", out_data.byte_valid, want.byte_valid);
        if (out_data.frame_status != want.frame_status)
          report_mismatch("frame_status", out_data.frame_status, want.frame_status);
        if (out_data.buffer_done != want.buffer_done)
          report_mismatch("buffer_done", out_data.buffer_done, want.buffer_done);
        if (out_data.buffer_status != want.buffer_status)
          report_mismatch("buffer_status", out_data.buffer_status, want.buffer_status);
        if (out_data.last != want.last)
          report_mismatch("last", out_data.last, want.last);
        if (want.frame_status == fea_pkg::FS_COMMIT) n_commits++;
        if (want.frame_status == fea_pkg::FS_ABORT) n_aborts++;
      end
    end
  end

  // Give up if the run stops making progress.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d requests and %0d results outstanding.",
               pending.size(), due_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/fea_pkg.sv
rtl/fea_front.sv
rtl/fea_queue.sv
rtl/fea_back.sv
rtl/frame_extract_and_restuff.sv
test/tb.sv
